FILE: rtl/lsmb_pkg.sv
`default_nettype none
// ============================================================================
// lsmb_pkg: shared types for the line sensor mean binarizer
// Holds the channel payload structs, field widths and the command group that
// the controller sends to the datapath.
// ============================================================================
package lsmb_pkg;

   // Fixed field widths of the two channels.
   localparam int SAMPLE_W = 12;
   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 5;

   // One x/y sample pair.
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_x;
      logic [SAMPLE_W-1:0] sample_y;
   } req_payload_type;

   // One packed result byte with its place in the frame.
   typedef struct packed {
      logic [BYTE_W-1:0]  packed_byte;
      logic [INDEX_W-1:0] byte_index;
      logic               last_byte;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       wr_en;        // store the incoming pair and add it to the sums
      logic       rd_en;        // read one stored pair
      logic       eval_en;      // compare the read sample and set its bit
      logic       axis;         // 0 selects x, 1 selects y
      logic [2:0] bit_sel;      // bit position of the pixel within its byte
      logic       clear_byte;   // first pixel of a byte starts from zero
      logic       clear_totals; // frame finished with the sums
   } cmd_type;

endpackage
`default_nettype wire

FILE: rtl/lsmb_ctrl.sv
`default_nettype none
// ============================================================================
// lsmb_ctrl: frame sequencer of the line sensor mean binarizer
// Counts loaded pairs, walks the stored pixels of each axis one at a time and
// hands each finished byte to the result channel.
// ============================================================================
module lsmb_ctrl #(
   parameter int FRAME_PIXELS = 128,
   parameter int ADDR_BITS    = 7
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output lsmb_pkg::cmd_type             cmd,
   output logic [ADDR_BITS-1:0]          mem_addr,
   output logic [lsmb_pkg::INDEX_W-1:0]  byte_index,
   output logic                          last_byte
);
   import lsmb_pkg::*;

   localparam logic [1:0] ST_LOAD = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_EVAL = 2'd2;
   localparam logic [1:0] ST_SEND = 2'd3;

   localparam logic [ADDR_BITS-1:0] LAST_PIX = ADDR_BITS'(FRAME_PIXELS - 1);

   logic [1:0]           state_ff, state_in;
   logic [ADDR_BITS-1:0] load_cnt_ff, load_cnt_in;
   logic [ADDR_BITS-1:0] pix_ff, pix_in;
   logic                 axis_ff, axis_in;
   logic [INDEX_W-1:0]   idx_ff, idx_in;

   logic last_pix;
   logic frame_last;
   logic in_take;
   logic out_take;

   // Handshake and position flags.
   assign last_pix   = (pix_ff == LAST_PIX);
   assign frame_last = axis_ff & last_pix;
   assign rsp_valid  = (state_ff == ST_SEND);
   // The first pair of the next frame may enter while the final byte waits.
   assign req_stall  = !((state_ff == ST_LOAD) ||
                         ((state_ff == ST_SEND) && frame_last &&
                          (load_cnt_ff == '0)));
   assign in_take    = req_valid & ~req_stall;
   assign out_take   = rsp_valid & ~rsp_stall;

   // Next-state logic of the sequencer.
   always_comb begin
      state_in    = state_ff;
      load_cnt_in = load_cnt_ff;
      pix_in      = pix_ff;
      axis_in     = axis_ff;
      idx_in      = idx_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (in_take) begin
               if (load_cnt_ff == LAST_PIX) begin
                  load_cnt_in = '0;
                  pix_in      = '0;
                  axis_in     = 1'b0;
                  state_in    = ST_READ;
               end else begin
                  load_cnt_in = load_cnt_ff + 1'b1;
               end
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if ((pix_ff[2:0] == 3'd7) || last_pix) begin
               state_in = ST_SEND;
            end else begin
               pix_in   = pix_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_SEND: begin
            if (in_take) begin
               load_cnt_in = load_cnt_ff + 1'b1;
            end
            if (out_take) begin
               idx_in = idx_ff + 1'b1;
               if (frame_last) begin
                  idx_in   = '0;
                  state_in = ST_LOAD;
               end else if (last_pix) begin
                  axis_in  = 1'b1;
                  pix_in   = '0;
                  state_in = ST_READ;
               end else begin
                  pix_in   = pix_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         load_cnt_ff <= '0;
         pix_ff      <= '0;
         axis_ff     <= 1'b0;
         idx_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         pix_ff      <= pix_in;
         axis_ff     <= axis_in;
         idx_ff      <= idx_in;
      end
   end

   // Commands to the datapath.
   always_comb begin
      cmd.wr_en        = in_take;
      cmd.rd_en        = (state_ff == ST_READ);
      cmd.eval_en      = (state_ff == ST_EVAL);
      cmd.axis         = axis_ff;
      cmd.bit_sel      = ~pix_ff[2:0];
      cmd.clear_byte   = (pix_ff[2:0] == 3'd0);
      cmd.clear_totals = (state_ff == ST_EVAL) && frame_last;
   end

   assign mem_addr   = (state_ff == ST_READ) ? pix_ff : load_cnt_ff;
   assign byte_index = idx_ff;
   assign last_byte  = frame_last;

endmodule
`default_nettype wire

FILE: rtl/lsmb_datapath.sv
`default_nettype none
// ============================================================================
// lsmb_datapath: sample store, axis sums and bit packing
// Keeps the frame's pairs in one memory, sums each axis and builds each
// result byte one compared pixel at a time.
// ============================================================================
module lsmb_datapath #(
   parameter int FRAME_PIXELS = 128,
   parameter int STORE_BITS   = 12,
   parameter int ADDR_BITS    = 7
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire lsmb_pkg::cmd_type         cmd,
   input  wire logic [ADDR_BITS-1:0]      mem_addr,
   input  wire lsmb_pkg::req_payload_type req_payload,
   output logic [lsmb_pkg::BYTE_W-1:0]    packed_byte
);
   import lsmb_pkg::*;

   localparam int SUM_BITS  = STORE_BITS + $clog2(FRAME_PIXELS + 1);
   localparam int WORD_BITS = 2 * STORE_BITS;

   logic [WORD_BITS-1:0] mem [FRAME_PIXELS];
   logic [WORD_BITS-1:0] rd_ff;
   logic [SUM_BITS-1:0]  x_total_ff, x_total_in;
   logic [SUM_BITS-1:0]  y_total_ff, y_total_in;
   logic [BYTE_W-1:0]    byte_ff, byte_in;

   logic [STORE_BITS-1:0] wr_x;
   logic [STORE_BITS-1:0] wr_y;
   logic [STORE_BITS-1:0] sample;
   logic [SUM_BITS-1:0]   total;
   logic [SUM_BITS-1:0]   scaled;
   logic                  at_or_above;

   // Bits above the stored sample width are dropped.
   assign wr_x = req_payload.sample_x[STORE_BITS-1:0];
   assign wr_y = req_payload.sample_y[STORE_BITS-1:0];

   // Sample store: y in the upper half of the word, x in the lower.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[mem_addr] <= {wr_y, wr_x};
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[mem_addr];
      end
   end

   // Running axis sums, cleared once the frame's compares are done.
   always_comb begin
      if (cmd.clear_totals) begin
         x_total_in = '0;
         y_total_in = '0;
      end else if (cmd.wr_en) begin
         x_total_in = x_total_ff + SUM_BITS'(wr_x);
         y_total_in = y_total_ff + SUM_BITS'(wr_y);
      end else begin
         x_total_in = x_total_ff;
         y_total_in = y_total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_total_ff <= '0;
         y_total_ff <= '0;
      end else begin
         x_total_ff <= x_total_in;
         y_total_ff <= y_total_in;
      end
   end

   // Mean test without division: sample * pixels >= sum.
   assign sample      = cmd.axis ? rd_ff[WORD_BITS-1:STORE_BITS] : rd_ff[STORE_BITS-1:0];
   assign total       = cmd.axis ? y_total_ff : x_total_ff;
   assign scaled      = SUM_BITS'(sample) * SUM_BITS'(FRAME_PIXELS);
   assign at_or_above = (scaled >= total);

   // Set the pixel's bit; the first pixel of a byte clears the rest.
   always_comb begin
      byte_in = byte_ff;
      if (cmd.eval_en) begin
         if (cmd.clear_byte) begin
            byte_in = '0;
         end
         byte_in[cmd.bit_sel] = at_or_above;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign packed_byte = byte_ff;

endmodule
`default_nettype wire

FILE: rtl/line_sensor_mean_binarizer.sv
`default_nettype none
// ============================================================================
// line_sensor_mean_binarizer: mean-threshold binarization of a two-axis frame
// Loads a frame of x/y sample pairs, then sends one bit per pixel, packed
// eight to a byte, set where the sample is at or above its axis mean.
// ============================================================================
//
//   Channel   Direction   Payload            Handshake
//   req_      in          x/y sample pair    req_valid / req_stall
//   rsp_      out         packed result byte rsp_valid / rsp_stall
//
// Loading takes one pair per cycle. After the last pair the block reads the
// store one pixel at a time (memory read, then compare) and holds each
// finished byte for one transfer; req_stall is high during the readout,
// except that the first pair of the next frame is taken while the final
// byte waits. Reset is synchronous; the sample store is not cleared, every
// entry is written before it is read. A stalled result byte holds the
// readout.
module line_sensor_mean_binarizer #(
   parameter int FRAME_PIXELS = 128,
   parameter int SAMPLE_BITS  = 12
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire lsmb_pkg::req_payload_type req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output lsmb_pkg::rsp_payload_type      rsp_payload
);
   import lsmb_pkg::*;

   localparam int STORE_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam int ADDR_BITS  = $clog2(FRAME_PIXELS);

   cmd_type              cmd;
   logic [ADDR_BITS-1:0] mem_addr;
   logic [BYTE_W-1:0]    packed_byte;
   logic [INDEX_W-1:0]   byte_index;
   logic                 last_byte;

   // Frame sequencer.
   lsmb_ctrl #(
      .FRAME_PIXELS (FRAME_PIXELS),
      .ADDR_BITS    (ADDR_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .mem_addr   (mem_addr),
      .byte_index (byte_index),
      .last_byte  (last_byte)
   );

   // Store, sums and bit packing.
   lsmb_datapath #(
      .FRAME_PIXELS (FRAME_PIXELS),
      .STORE_BITS   (STORE_BITS),
      .ADDR_BITS    (ADDR_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .mem_addr    (mem_addr),
      .req_payload (req_payload),
      .packed_byte (packed_byte)
   );

   // Result payload.
   always_comb begin
      rsp_payload.packed_byte = packed_byte;
      rsp_payload.byte_index  = byte_index;
      rsp_payload.last_byte   = last_byte;
   end

endmodule
`default_nettype wire
